[rtl/ssdf_pkg.sv]
// Shared types, codes and constants for the six-digit seven-segment formatter.
// Holds the mode and register index codes and the digit-to-segment encoder.
// No dependencies; every other file of the block imports this package.
package ssdf_pkg;

  localparam int VAL_W      = 20;
  localparam int DIG_W      = 4;
  localparam int SEG_W      = 8;
  localparam int NUM_DIGITS = 6;

  // Display modes as written to the mode register.
  localparam logic [1:0] MODE_SPEED   = 2'd0;
  localparam logic [1:0] MODE_MILEAGE = 2'd1;
  localparam logic [1:0] MODE_TIME    = 2'd2;
  localparam logic [1:0] MODE_TOP     = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_IDX_MODE   = 1'b0;
  localparam logic CFG_IDX_OFFSET = 1'b1;

  localparam logic [1:0]       MODE_RST        = MODE_SPEED;
  localparam logic [4:0]       HOUR_OFFSET_RST = 5'd8;
  localparam logic [VAL_W-1:0] NUM_MAX         = 20'd999999;

  localparam logic [SEG_W-1:0] SEG_OFF   = 8'h00;
  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;

  typedef logic [DIG_W-1:0] digit_t;
  // Element 0 is the leftmost digit.
  typedef digit_t [NUM_DIGITS-1:0] digits_t;

  // Control that travels alongside the data through the pipeline.
  typedef struct packed {
    logic       vld;
    logic [1:0] mode;
    logic       dash;
  } ctl_t;

  function automatic logic [SEG_W-1:0] seg_of(input digit_t d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = SEG_OFF;
    endcase
    return s;
  endfunction

endpackage

[rtl/seven_segment_display_formatter_top.sv]
// Top level of the six-digit seven-segment display formatter.
// Holds the configuration registers, the time path and the segment encoding.
// Depends on ssdf_pkg and ssdf_bcd6.
//
//   Channel  Ports                                        Handshake
//   -------  -------------------------------------------  ---------------------------
//   update   in_fix_valid .. in_utc_second                start, taken when busy low
//   result   out_seg_0 .. out_seg_5                       out_valid strobe, one cycle
//   config   cfg_index, cfg_wdata                         cfg_we, written at once
//
// One word is accepted every cycle while busy is low; each result follows its
// word through the input register, the two converter stages and the result
// register. The receiver cannot stall, so nothing ever holds the
// pipeline. busy is high only while rst_n is low. Reset is synchronous and
// clears the pipeline valid bits and loads speed mode with an hour offset of 8.
module seven_segment_display_formatter_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_fix_valid,
  input  logic [ssdf_pkg::VAL_W-1:0]           in_speed_tenths,
  input  logic [ssdf_pkg::VAL_W-1:0]           in_distance_hundredths,
  input  logic [ssdf_pkg::VAL_W-1:0]           in_top_speed_tenths,
  input  logic [4:0]                           in_utc_hour,
  input  logic [5:0]                           in_utc_minute,
  input  logic [5:0]                           in_utc_second,
  output logic                                 out_valid,
  output logic [ssdf_pkg::SEG_W-1:0]           out_seg_0,
  output logic [ssdf_pkg::SEG_W-1:0]           out_seg_1,
  output logic [ssdf_pkg::SEG_W-1:0]           out_seg_2,
  output logic [ssdf_pkg::SEG_W-1:0]           out_seg_3,
  output logic [ssdf_pkg::SEG_W-1:0]           out_seg_4,
  output logic [ssdf_pkg::SEG_W-1:0]           out_seg_5,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [4:0]                           cfg_wdata
);
  import ssdf_pkg::*;

  // Tens and units of a two-digit value below 64.
  function automatic logic [7:0] two_digits(input logic [5:0] x);
    logic [13:0] p;
    digit_t      t;
    logic [7:0]  t10;
    digit_t      u;
    p   = {8'b0, x} * 14'd205;
    t   = {1'b0, p[13:11]};
    t10 = {4'b0, t} * 8'd10;
    u   = x[3:0] - t10[3:0];
    return {t, u};
  endfunction

  logic             accept;
  logic [1:0]       mode_r;
  logic [4:0]       offset_r;

  // Input register.
  logic             vld0_r;
  logic             fix0_r;
  logic [1:0]       mode0_r;
  logic [VAL_W-1:0] spd0_r, dist0_r, top0_r;
  logic [4:0]       hh0_r;
  logic [5:0]       mm0_r, ss0_r;

  logic [VAL_W-1:0] num_sel;
  digits_t          num_digits;

  logic [5:0]       hour_sum, hour_loc;
  logic [7:0]       hh_tu, mm_tu, ss_tu;
  ctl_t             ctl1_nxt, ctl1_r, ctl2_r;
  digits_t          tim1_nxt, tim1_r, tim2_r;

  logic [NUM_DIGITS-1:0][SEG_W-1:0] seg_nxt, seg_r;
  logic             out_valid_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // Configuration registers; the user must write them only while the pipeline is empty; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      offset_r <= HOUR_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_MODE:   mode_r   <= cfg_wdata[1:0];
        CFG_IDX_OFFSET: offset_r <= cfg_wdata;
        default:        mode_r   <= mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    fix0_r  <= in_fix_valid;
    mode0_r <= mode_r;
    spd0_r  <= in_speed_tenths;
    dist0_r <= in_distance_hundredths;
    top0_r  <= in_top_speed_tenths;
    hh0_r   <= in_utc_hour;
    mm0_r   <= in_utc_minute;
    ss0_r   <= in_utc_second;
  end

  // Numeric path: pick the value for the mode and convert it to six digits.
  always_comb begin
    case (mode0_r)
      MODE_MILEAGE: num_sel = dist0_r;
      MODE_TOP:     num_sel = top0_r;
      default:      num_sel = spd0_r;
    endcase
  end

  ssdf_bcd6 u_bcd6 (
    .clk    (clk),
    .value  (num_sel),
    .digits (num_digits)
  );

  // Time path: the local hour wraps at 24; the sum never reaches 72, so two
  // compares cover every offset the register can hold.
  assign hour_sum = {1'b0, hh0_r} + {1'b0, offset_r};
  always_comb begin
    if (hour_sum >= 6'd48) begin
      hour_loc = hour_sum - 6'd48;
    end else if (hour_sum >= 6'd24) begin
      hour_loc = hour_sum - 6'd24;
    end else begin
      hour_loc = hour_sum;
    end
  end

  assign hh_tu = two_digits(hour_loc);
  assign mm_tu = two_digits(mm0_r);
  assign ss_tu = two_digits(ss0_r);

  assign tim1_nxt[0] = hh_tu[7:4];
  assign tim1_nxt[1] = hh_tu[3:0];
  assign tim1_nxt[2] = mm_tu[7:4];
  assign tim1_nxt[3] = mm_tu[3:0];
  assign tim1_nxt[4] = ss_tu[7:4];
  assign tim1_nxt[5] = ss_tu[3:0];

  // Without a fix, speed and time modes show dashes; the other modes ignore it.
  assign ctl1_nxt.vld  = vld0_r;
  assign ctl1_nxt.mode = mode0_r;
  assign ctl1_nxt.dash = ~fix0_r & ((mode0_r == MODE_SPEED) | (mode0_r == MODE_TIME));

  // The time digits and control follow the two converter stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    tim1_r <= tim1_nxt;
    tim2_r <= tim1_r;
  end

  // Segment encoding. In the numeric modes leading zeros are blanked up to
  // the last integer digit, which carries the decimal point.
  always_comb begin
    logic [2:0] dp_pos;
    logic       lead;
    dp_pos  = (ctl2_r.mode == MODE_MILEAGE) ? 3'd3 : 3'd4;
    lead    = 1'b1;
    seg_nxt = '0;
    if (ctl2_r.dash) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        seg_nxt[i] = SEG_MINUS;
      end
    end else if (ctl2_r.mode == MODE_TIME) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        seg_nxt[i] = seg_of(tim2_r[i]);
      end
      seg_nxt[1] = seg_nxt[1] | SEG_DP;
      seg_nxt[3] = seg_nxt[3] | SEG_DP;
    end else begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        if (lead && (num_digits[i] == 4'd0) && (3'(i) < dp_pos)) begin
          seg_nxt[i] = SEG_OFF;
        end else begin
          lead       = 1'b0;
          seg_nxt[i] = seg_of(num_digits[i]);
        end
        if (3'(i) == dp_pos) begin
          seg_nxt[i] = seg_nxt[i] | SEG_DP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl2_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= seg_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_seg_0 = seg_r[0];
  assign out_seg_1 = seg_r[1];
  assign out_seg_2 = seg_r[2];
  assign out_seg_3 = seg_r[3];
  assign out_seg_4 = seg_r[4];
  assign out_seg_5 = seg_r[5];

endmodule

[rtl/ssdf_bcd6.sv]
// Two-stage binary to six-digit decimal converter with saturation at 999999.
// Splits the value into thousands and remainder, then each half into digits.
// Depends on ssdf_pkg.
module ssdf_bcd6 (
  input  logic                        clk,
  input  logic [ssdf_pkg::VAL_W-1:0]  value,
  output ssdf_pkg::digits_t           digits
);
  import ssdf_pkg::*;

  // ceil(2^30 / 1000); exact quotient for every value up to 999999.
  localparam logic [20:0] RECIP_1000 = 21'd1073742;

  // Hundreds digit of a value below 1000.
  function automatic digit_t hundreds(input logic [9:0] x);
    logic [15:0] p;
    p = {6'b0, x} * 16'd41;
    return p[15:12];
  endfunction

  // Tens and units digits of a value below 1000 whose hundreds digit is c.
  function automatic logic [7:0] tens_units(input logic [9:0] x, input digit_t c);
    logic [10:0] c100;
    logic [6:0]  r;
    logic [14:0] p;
    digit_t      t;
    logic [7:0]  t10;
    digit_t      u;
    c100 = {7'b0, c} * 11'd100;
    r    = x[6:0] - c100[6:0];
    p    = {8'b0, r} * 15'd205;
    t    = p[14:11];
    t10  = {4'b0, t} * 8'd10;
    u    = r[3:0] - t10[3:0];
    return {t, u};
  endfunction

  logic [VAL_W-1:0] sat;
  logic [40:0]      prod;
  logic [VAL_W-1:0] val_r;
  logic [9:0]       thou_r, thou_nxt;
  logic [19:0]      q1000;
  logic [9:0]       hi_r, lo_r, lo_nxt;
  digit_t           hi_c_r, lo_c_r;
  logic [7:0]       hi_tu, lo_tu;

  assign sat      = (value > NUM_MAX) ? NUM_MAX : value;
  assign prod     = {21'b0, sat} * {20'b0, RECIP_1000};
  assign thou_nxt = prod[39:30];

  always_ff @(posedge clk) begin
    val_r  <= sat;
    thou_r <= thou_nxt;
  end

  // The remainder is below 1000, so only the low ten bits matter.
  assign q1000  = {10'b0, thou_r} * 20'd1000;
  assign lo_nxt = val_r[9:0] - q1000[9:0];

  always_ff @(posedge clk) begin
    hi_r   <= thou_r;
    lo_r   <= lo_nxt;
    hi_c_r <= hundreds(thou_r);
    lo_c_r <= hundreds(lo_nxt);
  end

  assign hi_tu = tens_units(hi_r, hi_c_r);
  assign lo_tu = tens_units(lo_r, lo_c_r);

  assign digits[0] = hi_c_r;
  assign digits[1] = hi_tu[7:4];
  assign digits[2] = hi_tu[3:0];
  assign digits[3] = lo_c_r;
  assign digits[4] = lo_tu[7:4];
  assign digits[5] = lo_tu[3:0];

endmodule

[rtl/ssdf_checker.sv]
// Port-level checker for the seven-segment display formatter, bound to the top.
// Watches the update and result channels for latency and result shape.
// Depends on ssdf_pkg and seven_segment_display_formatter_top.
module ssdf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [ssdf_pkg::SEG_W-1:0] out_seg_0,
  input logic [ssdf_pkg::SEG_W-1:0] out_seg_1,
  input logic [ssdf_pkg::SEG_W-1:0] out_seg_2,
  input logic [ssdf_pkg::SEG_W-1:0] out_seg_3,
  input logic [ssdf_pkg::SEG_W-1:0] out_seg_4,
  input logic [ssdf_pkg::SEG_W-1:0] out_seg_5
);
  import ssdf_pkg::*;

  // Every accepted word yields a result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted word produced no result");

  // No result appears without an earlier accepted word.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without an accepted word");

  // A dash never mixes with digits: a dashed left digit means a dashed word.
  a_dash_all: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_seg_0 == SEG_MINUS)) |->
      ((out_seg_1 == SEG_MINUS) && (out_seg_2 == SEG_MINUS) && (out_seg_3 == SEG_MINUS)
       && (out_seg_4 == SEG_MINUS) && (out_seg_5 == SEG_MINUS)))
    else $error("partial dash pattern");

  // The rightmost digit never carries the decimal point.
  a_last_dp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_seg_5[SEG_W-1])
    else $error("decimal point on rightmost digit");

endmodule

bind seven_segment_display_formatter_top ssdf_checker u_ssdf_checker (.*);
